// ===== rtl/core/bsre_pkg.sv =====
// Shared types, constants and helpers for the blended shape raster engine.
// Used by bsre_frame_ram and blended_shape_raster_engine; depends on nothing.
package bsre_pkg;

   // Frame geometry (power-of-two sizes, row-major addressing)
   localparam int FB_WIDTH   = 256;
   localparam int FB_HEIGHT  = 256;
   localparam int FB_W_BITS  = $clog2(FB_WIDTH);
   localparam int FB_H_BITS  = $clog2(FB_HEIGHT);
   localparam int ADDR_BITS  = FB_W_BITS + FB_H_BITS;
   localparam int PIXEL_BITS = 32;

   localparam logic [7:0] CH_MAX = 8'hff;

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic signed [15:0]    coord_type;
   typedef logic signed [17:0]    sq_type;

   // Command codes
   typedef enum logic [1:0] {
      OP_RECT   = 2'd0,
      OP_LINE   = 2'd1,
      OP_CIRCLE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SETUP,
      S_CINIT,
      S_LSTEP,
      S_PIX,
      S_MUL,
      S_WRITE,
      S_RWAIT,
      S_RESP
   } state_type;

   // floor(x / 255) for x <= 255*255, shift-add form
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'd1 + 17'(x[15:8]);
      return t[15:8];
   endfunction

endpackage

// ===== rtl/core/bsre_frame_ram.sv =====
// Frame store: single-port-write, single-port-read synchronous memory.
// Read data is registered. Depends on bsre_pkg.
module bsre_frame_ram (
   input  logic                clock,
   input  logic                wr_en,
   input  bsre_pkg::addr_type  wr_addr,
   input  bsre_pkg::pixel_type wr_data,
   input  logic                rd_en,
   input  bsre_pkg::addr_type  rd_addr,
   output bsre_pkg::pixel_type rd_data
);
   import bsre_pkg::*;

   pixel_type mem [0:(1 << ADDR_BITS)-1];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/blended_shape_raster_engine.sv =====
// Blended shape raster engine: top level with command sequencer and blender.
// Depends on bsre_pkg and bsre_frame_ram.
//
// Draws rectangles, thick lines and filled circles into a 256x256 ARGB frame
// store with source-over blending, and reads single pixels. One command is
// worked at a time; each returns one response word. A drawn pixel goes through
// read, multiply, and divide-and-write steps through the single frame memory;
// each skipped candidate (clipped, off-frame, or outside the circle) takes only
// the plot test, each line step adds a state for its center, and a circle has
// an extra setup state. After reset a clearing pass writes zero to all 65536
// pixels, one per cycle, before the first command is taken.
module blended_shape_raster_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [8:0]  req_clip_left,
   input  logic [8:0]  req_clip_top,
   input  logic [8:0]  req_clip_right,
   input  logic [8:0]  req_clip_bottom,
   input  logic signed [11:0] req_x_a,
   input  logic signed [11:0] req_y_a,
   input  logic signed [11:0] req_x_b,
   input  logic signed [11:0] req_y_b,
   input  logic [4:0]  req_brush_width,
   input  logic [7:0]  req_radius,
   input  logic [31:0] req_draw_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_color,
   output logic        rsp_was_read
);
   import bsre_pkg::*;

   localparam coord_type FB_W_C = coord_type'(FB_WIDTH);
   localparam coord_type FB_H_C = coord_type'(FB_HEIGHT);

   state_type state_ff, state_in;

   // command word
   op_type            op_ff, op_in;
   logic [8:0]        cl_ff, cl_in, ct_ff, ct_in, cr_ff, cr_in, cb_ff, cb_in;
   logic signed [11:0] xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic [4:0]        bw_ff, bw_in;
   logic [7:0]        rad_ff, rad_in;
   pixel_type         color_ff, color_in;

   // pixel scan
   addr_type  clr_ff, clr_in;
   coord_type ox_ff, ox_in, oy_ff, oy_in, bx_ff, bx_in, by_ff, by_in;
   coord_type xlo_ff, xlo_in, xhi_ff, xhi_in, ylo_ff, ylo_in, yhi_ff, yhi_in;
   sq_type    sq_ff, sq_in, dy2_ff, dy2_in, r2_ff, r2_in;

   // line stepping
   coord_type   maj_ff, maj_in, majend_ff, majend_in, minbase_ff, minbase_in;
   logic [12:0] q_ff, q_in, acc_ff, acc_in, dmabs_ff, dmabs_in, dmaj_ff, dmaj_in;
   logic        dmneg_ff, dmneg_in, xmaj_ff, xmaj_in;

   // blend products, read flag, response
   logic [15:0] prod_ff [4];
   logic [15:0] prod_in [4];
   logic        inframe_ff, inframe_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pixel_type   rsp_color_ff, rsp_color_in;
   logic        rsp_was_read_ff, rsp_was_read_in;

   // memory port
   logic      wr_en, rd_en;
   addr_type  wr_addr, rd_addr;
   pixel_type wr_data, rd_data;

   bsre_frame_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // current candidate pixel
   coord_type px, py, clx, cty, crx, cby;
   logic      plot_ok;
   addr_type  pix_addr;

   assign px  = bx_ff + ox_ff;
   assign py  = by_ff + oy_ff;
   assign clx = coord_type'({7'b0, cl_ff});
   assign cty = coord_type'({7'b0, ct_ff});
   assign crx = coord_type'({7'b0, cr_ff});
   assign cby = coord_type'({7'b0, cb_ff});
   assign pix_addr = {py[FB_H_BITS-1:0], px[FB_W_BITS-1:0]};

   always_comb begin
      plot_ok = (px >= clx) && (px < crx) && (py >= cty) && (py < cby) &&
                (px >= 0) && (px < FB_W_C) && (py >= 0) && (py < FB_H_C);
      if (op_ff == OP_CIRCLE && sq_ff > r2_ff) begin
         plot_ok = 1'b0;
      end
   end

   // scan advance: next brush / rect / circle position
   coord_type adv_ox, adv_oy;
   sq_type    adv_sq, adv_dy2, step_x, step_y;
   logic      inner_done;

   always_comb begin
      step_x     = sq_type'(ox_ff) + sq_type'(ox_ff) + sq_type'(1);
      step_y     = sq_type'(oy_ff) + sq_type'(oy_ff) + sq_type'(1);
      adv_ox     = ox_ff;
      adv_oy     = oy_ff;
      adv_sq     = sq_ff;
      adv_dy2    = dy2_ff;
      inner_done = 1'b0;
      if (ox_ff != xhi_ff) begin
         adv_ox = ox_ff + coord_type'(1);
         adv_sq = sq_ff + step_x;
      end else begin
         adv_ox = xlo_ff;
         if (oy_ff != yhi_ff) begin
            adv_oy  = oy_ff + coord_type'(1);
            adv_dy2 = dy2_ff + step_y;
            adv_sq  = dy2_ff + step_y + r2_ff;
         end else begin
            inner_done = 1'b1;
         end
      end
   end

   // line step: minor offset accumulator, one compare-subtract a step
   logic [13:0] acc_sum;
   logic        acc_carry;
   coord_type   minor_c, cx_c, cy_c;

   assign acc_sum   = 14'(acc_ff) + 14'(dmabs_ff);
   assign acc_carry = acc_sum >= 14'(dmaj_ff);
   assign minor_c   = dmneg_ff ? minbase_ff - coord_type'({3'b0, q_ff})
                               : minbase_ff + coord_type'({3'b0, q_ff});
   assign cx_c      = xmaj_ff ? maj_ff : minor_c;
   assign cy_c      = xmaj_ff ? minor_c : maj_ff;

   // setup values
   coord_type sxa, sya, sxb, syb, ldx, ldy, adx, ady, dmin, half;
   coord_type xs, xe, ys, ye, t0, t1;
   logic      lswap, lxmaj;

   always_comb begin
      sxa   = coord_type'(xa_ff);
      sya   = coord_type'(ya_ff);
      sxb   = coord_type'(xb_ff);
      syb   = coord_type'(yb_ff);
      ldx   = sxb - sxa;
      ldy   = syb - sya;
      adx   = ldx[15] ? -ldx : ldx;
      ady   = ldy[15] ? -ldy : ldy;
      lxmaj = adx > ady;
      lswap = lxmaj ? (sxa > sxb) : (sya > syb);
      if (lxmaj) begin
         dmin = lswap ? sya - syb : syb - sya;
      end else begin
         dmin = lswap ? sxa - sxb : sxb - sxa;
      end
      half = coord_type'({11'b0, bw_ff[4:1]});
      // rectangle bounds, clipped to the origin side and frame
      t0 = sxa + clx;
      xs = (t0 > clx) ? t0 : clx;
      t1 = sxb + clx;
      xe = (t1 < crx) ? t1 : crx;
      if (xe > FB_W_C) begin
         xe = FB_W_C;
      end
      ys = (sya + cty > cty) ? sya + cty : cty;
      ye = (syb + cty < cby) ? syb + cty : cby;
      if (ye > FB_H_C) begin
         ye = FB_H_C;
      end
   end

   // blend terms
   logic [7:0] src_a, inv_a;
   assign src_a = color_ff[31:24];
   assign inv_a = CH_MAX - src_a;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      op_in = op_ff; cl_in = cl_ff; ct_in = ct_ff; cr_in = cr_ff; cb_in = cb_ff;
      xa_in = xa_ff; ya_in = ya_ff; xb_in = xb_ff; yb_in = yb_ff;
      bw_in = bw_ff; rad_in = rad_ff; color_in = color_ff;
      clr_in = clr_ff;
      ox_in = ox_ff; oy_in = oy_ff; bx_in = bx_ff; by_in = by_ff;
      xlo_in = xlo_ff; xhi_in = xhi_ff; ylo_in = ylo_ff; yhi_in = yhi_ff;
      sq_in = sq_ff; dy2_in = dy2_ff; r2_in = r2_ff;
      maj_in = maj_ff; majend_in = majend_ff; minbase_in = minbase_ff;
      q_in = q_ff; acc_in = acc_ff; dmabs_in = dmabs_ff; dmaj_in = dmaj_ff;
      dmneg_in = dmneg_ff; xmaj_in = xmaj_ff;
      prod_in         = prod_ff;
      inframe_in      = inframe_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_color_in    = rsp_color_ff;
      rsp_was_read_in = rsp_was_read_ff;
      wr_en   = 1'b0;
      wr_addr = pix_addr;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = pix_addr;
      req_stall = (state_ff != S_IDLE);

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + addr_type'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in = op_type'(req_operation);
               cl_in = req_clip_left;   ct_in = req_clip_top;
               cr_in = req_clip_right;  cb_in = req_clip_bottom;
               xa_in = req_x_a; ya_in = req_y_a; xb_in = req_x_b; yb_in = req_y_b;
               bw_in = req_brush_width; rad_in = req_radius;
               color_in = req_draw_color;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            case (op_ff)
               OP_RECT: begin
                  bx_in = '0; by_in = '0;
                  ox_in = xs; xlo_in = xs; xhi_in = xe - coord_type'(1);
                  oy_in = ys; ylo_in = ys; yhi_in = ye - coord_type'(1);
                  state_in = (xs >= xe || ys >= ye) ? S_RESP : S_PIX;
               end
               OP_LINE: begin
                  xlo_in = -half; xhi_in = half; ylo_in = -half; yhi_in = half;
                  xmaj_in  = lxmaj;
                  if (lxmaj) begin
                     maj_in     = lswap ? sxb : sxa;
                     majend_in  = lswap ? sxa : sxb;
                     minbase_in = lswap ? syb : sya;
                     dmaj_in    = adx[12:0];
                  end else begin
                     maj_in     = lswap ? syb : sya;
                     majend_in  = lswap ? sya : syb;
                     minbase_in = lswap ? sxb : sxa;
                     dmaj_in    = ady[12:0];
                  end
                  dmneg_in = dmin[15];
                  dmabs_in = dmin[15] ? 13'(-dmin) : dmin[12:0];
                  q_in     = '0;
                  acc_in   = '0;
                  state_in = (ldx == 0 && ldy == 0) ? S_RESP : S_LSTEP;
               end
               OP_CIRCLE: begin
                  bx_in  = sxa; by_in = sya;
                  xlo_in = -coord_type'({8'b0, rad_ff});
                  xhi_in = coord_type'({8'b0, rad_ff});
                  ylo_in = -coord_type'({8'b0, rad_ff});
                  yhi_in = coord_type'({8'b0, rad_ff});
                  ox_in  = -coord_type'({8'b0, rad_ff});
                  oy_in  = -coord_type'({8'b0, rad_ff});
                  r2_in  = sq_type'({1'b0, 17'(rad_ff) * 17'(rad_ff)});
                  state_in = S_CINIT;
               end
               default: begin
                  inframe_in = (sxa >= 0) && (sxa < FB_W_C) &&
                               (sya >= 0) && (sya < FB_H_C);
                  rd_en   = 1'b1;
                  rd_addr = {sya[FB_H_BITS-1:0], sxa[FB_W_BITS-1:0]};
                  state_in = S_RWAIT;
               end
            endcase
            // non-read commands answer with a zero word
            rsp_color_in    = '0;
            rsp_was_read_in = (op_ff == OP_READ);
         end
         S_CINIT: begin
            dy2_in   = r2_ff;
            sq_in    = r2_ff + r2_ff;
            state_in = S_PIX;
         end
         S_LSTEP: begin
            bx_in = cx_c + clx;
            by_in = cy_c + cty;
            ox_in = xlo_ff;
            oy_in = ylo_ff;
            state_in = S_PIX;
         end
         S_PIX, S_WRITE: begin
            if (state_ff == S_PIX && plot_ok) begin
               rd_en    = 1'b1;
               state_in = S_MUL;
            end else begin
               if (state_ff == S_WRITE) begin
                  wr_en   = 1'b1;
                  wr_data = {div255(prod_ff[3]), div255(prod_ff[2]),
                             div255(prod_ff[1]), div255(prod_ff[0])};
               end
               ox_in  = adv_ox;
               oy_in  = adv_oy;
               sq_in  = adv_sq;
               dy2_in = adv_dy2;
               state_in = S_PIX;
               if (inner_done) begin
                  if (op_ff == OP_LINE && maj_ff != majend_ff) begin
                     maj_in   = maj_ff + coord_type'(1);
                     acc_in   = acc_carry ? 13'(acc_sum - 14'(dmaj_ff)) : acc_sum[12:0];
                     q_in     = acc_carry ? q_ff + 13'd1 : q_ff;
                     state_in = S_LSTEP;
                  end else begin
                     state_in = S_RESP;
                  end
               end
            end
         end
         S_MUL: begin
            prod_in[0] = 16'(rd_data[7:0])   * 16'(inv_a) + 16'(color_ff[7:0])   * 16'(src_a);
            prod_in[1] = 16'(rd_data[15:8])  * 16'(inv_a) + 16'(color_ff[15:8])  * 16'(src_a);
            prod_in[2] = 16'(rd_data[23:16]) * 16'(inv_a) + 16'(color_ff[23:16]) * 16'(src_a);
            prod_in[3] = 16'(rd_data[31:24]) * 16'(inv_a) + 16'(src_a) * 16'(CH_MAX);
            state_in = S_WRITE;
         end
         S_RWAIT: begin
            rsp_color_in = inframe_ff ? rd_data : '0;
            state_in     = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            if (rsp_valid_ff && !rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff <= op_in; cl_ff <= cl_in; ct_ff <= ct_in; cr_ff <= cr_in; cb_ff <= cb_in;
      xa_ff <= xa_in; ya_ff <= ya_in; xb_ff <= xb_in; yb_ff <= yb_in;
      bw_ff <= bw_in; rad_ff <= rad_in; color_ff <= color_in;
      ox_ff <= ox_in; oy_ff <= oy_in; bx_ff <= bx_in; by_ff <= by_in;
      xlo_ff <= xlo_in; xhi_ff <= xhi_in; ylo_ff <= ylo_in; yhi_ff <= yhi_in;
      sq_ff <= sq_in; dy2_ff <= dy2_in; r2_ff <= r2_in;
      maj_ff <= maj_in; majend_ff <= majend_in; minbase_ff <= minbase_in;
      q_ff <= q_in; acc_ff <= acc_in; dmabs_ff <= dmabs_in; dmaj_ff <= dmaj_in;
      dmneg_ff <= dmneg_in; xmaj_ff <= xmaj_in;
      prod_ff         <= prod_in;
      inframe_ff      <= inframe_in;
      rsp_color_ff    <= rsp_color_in;
      rsp_was_read_ff <= rsp_was_read_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_color = rsp_color_ff;
   assign rsp_was_read   = rsp_was_read_ff;

`ifndef SYNTHESIS
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_WRITE))
      else $error("frame write outside clear or blend write");
   a_mul_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> ($past(state_ff) == S_PIX && $past(rd_en)))
      else $error("blend multiply without a preceding pixel read");
   a_write_follows_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> ($past(state_ff) == S_MUL))
      else $error("blend write without multiply stage");
   a_rsp_only_in_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_RESP))
      else $error("response valid outside response state");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for blended_shape_raster_engine: draws, reads back and
// compares every response word against a behavioral frame-store model.
// Depends on bsre_pkg (op codes, frame size) and the engine RTL.
`timescale 1ns / 100ps

module testbench;
   import bsre_pkg::*;

   typedef struct {
      op_type            op;
      logic [8:0]        cl, ct, cr, cb;
      logic signed [11:0] xa, ya, xb, yb;
      logic [4:0]        bw;
      logic [7:0]        rad;
      logic [31:0]       color;
   } draw_cmd_type;

   typedef struct {
      logic [31:0] color;
      logic        was_read;
   } rsp_word_type;

   localparam int CYCLE_LIMIT = 4_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation = '0;
   logic [8:0]         req_clip_left = '0, req_clip_top = '0;
   logic [8:0]         req_clip_right = '0, req_clip_bottom = '0;
   logic signed [11:0] req_x_a = '0, req_y_a = '0, req_x_b = '0, req_y_b = '0;
   logic [4:0]         req_brush_width = '0;
   logic [7:0]         req_radius = '0;
   logic [31:0]        req_draw_color = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [31:0]        rsp_read_color;
   logic               rsp_was_read;

   blended_shape_raster_engine u_dut (.*);

   // Model state
   logic [31:0] frame_px [FB_WIDTH*FB_HEIGHT];
   int          clip_l, clip_t, clip_r, clip_b;

   draw_cmd_type cmd_queue [$];
   rsp_word_type rsp_expected [$];
   draw_cmd_type cur_cmd;
   int          cmds_sent, rsps_seen, mismatches, total_cmds;
   int          op_count [4];
   int          gap_left, stall_left, cycle_count;
   bit          held_long;

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------- frame-store model ----------------
   function automatic logic [31:0] over_blend(logic [31:0] dst, logic [31:0] src);
      int as, inv, a, r, g, b;
      as  = src[31:24];
      inv = 255 - as;
      r = (int'(dst[23:16]) * inv + int'(src[23:16]) * as) / 255;
      g = (int'(dst[15:8]) * inv + int'(src[15:8]) * as) / 255;
      b = (int'(dst[7:0]) * inv + int'(src[7:0]) * as) / 255;
      a = (int'(dst[31:24]) * inv + as * 255) / 255;
      return {a[7:0], r[7:0], g[7:0], b[7:0]};
   endfunction

   function automatic void put_px(int x, int y, logic [31:0] color);
      if (x < clip_l || x >= clip_r || y < clip_t || y >= clip_b) return;
      if (x < 0 || x >= FB_WIDTH || y < 0 || y >= FB_HEIGHT) return;
      frame_px[y*FB_WIDTH + x] = over_blend(frame_px[y*FB_WIDTH + x], color);
   endfunction

   function automatic void brush_stamp(int x, int y, int half, logic [31:0] color);
      for (int oy = -half; oy <= half; oy++)
         for (int ox = -half; ox <= half; ox++)
            put_px(x + ox + clip_l, y + oy + clip_t, color);
   endfunction

   function automatic void draw_line(int x1, int y1, int x2, int y2, int half,
                                     logic [31:0] color);
      int dx, dy, adx, ady, t;
      dx = x2 - x1;
      dy = y2 - y1;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      if (dx == 0 && dy == 0) return;
      if (adx > ady) begin
         if (x1 > x2) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
         end
         dx = x2 - x1; dy = y2 - y1;
         for (int s = x1; s <= x2; s++)
            brush_stamp(s, ((s - x1) * dy) / dx + y1, half, color);
      end else begin
         if (y1 > y2) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
         end
         dx = x2 - x1; dy = y2 - y1;
         for (int s = y1; s <= y2; s++)
            brush_stamp(((s - y1) * dx) / dy + x1, s, half, color);
      end
   endfunction

   // Apply one command to the model and return the word it should produce
   function automatic rsp_word_type raster_predict(draw_cmd_type c);
      rsp_word_type w;
      int xa, ya, xb, yb, xs, xe, ys, ye, r;
      xa = c.xa; ya = c.ya; xb = c.xb; yb = c.yb;
      clip_l = c.cl; clip_t = c.ct; clip_r = c.cr; clip_b = c.cb;
      w.color = '0;
      w.was_read = 1'b0;
      case (c.op)
         OP_RECT: begin
            xs = xa + clip_l > clip_l ? xa + clip_l : clip_l;
            if (xs < 0) xs = 0;
            xe = xb + clip_l < clip_r ? xb + clip_l : clip_r;
            if (xe > FB_WIDTH) xe = FB_WIDTH;
            ys = ya + clip_t > clip_t ? ya + clip_t : clip_t;
            if (ys < 0) ys = 0;
            ye = yb + clip_t < clip_b ? yb + clip_t : clip_b;
            if (ye > FB_HEIGHT) ye = FB_HEIGHT;
            for (int y = ys; y < ye; y++)
               for (int x = xs; x < xe; x++)
                  put_px(x, y, c.color);
         end
         OP_LINE: draw_line(xa, ya, xb, yb, int'(c.bw) / 2, c.color);
         OP_CIRCLE: begin
            r = c.rad;
            for (int dy = -r; dy <= r; dy++)
               for (int dx = -r; dx <= r; dx++)
                  if (dx*dx + dy*dy <= r*r) put_px(xa + dx, ya + dy, c.color);
         end
         default: begin
            if (xa >= 0 && xa < FB_WIDTH && ya >= 0 && ya < FB_HEIGHT)
               w.color = frame_px[ya*FB_WIDTH + xa];
            w.was_read = 1'b1;
         end
      endcase
      return w;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic draw_cmd_type mk_cmd(op_type op, int cl, int ct, int cr, int cb,
                                           int xa, int ya, int xb, int yb, int bw,
                                           int rad, logic [31:0] color);
      draw_cmd_type c;
      c.op = op; c.cl = 9'(cl); c.ct = 9'(ct); c.cr = 9'(cr); c.cb = 9'(cb);
      c.xa = 12'(xa); c.ya = 12'(ya); c.xb = 12'(xb); c.yb = 12'(yb);
      c.bw = 5'(bw); c.rad = 8'(rad); c.color = color;
      return c;
   endfunction

   function automatic int srand(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Small shapes near the origin so reads land on drawn pixels
   function automatic draw_cmd_type rand_cmd();
      draw_cmd_type c;
      int sel, cl, ct;
      sel = $urandom_range(99);
      c.cl = 9'($urandom); c.ct = 9'($urandom); c.cr = 9'($urandom); c.cb = 9'($urandom);
      c.xa = 12'($urandom); c.ya = 12'($urandom); c.xb = 12'($urandom); c.yb = 12'($urandom);
      c.bw = 5'($urandom); c.rad = 8'($urandom); c.color = $urandom;
      if (sel < 10) begin
         // noise: read anywhere, all fields random
         c.op = OP_READ;
         return c;
      end
      cl = $urandom_range(15);
      ct = $urandom_range(15);
      c.cl = 9'(cl);
      c.ct = 9'(ct);
      case ($urandom_range(9))
         0: begin c.cr = 9'($urandom_range(256)); c.cb = 9'($urandom_range(256)); end
         1: begin c.cr = 9'(256); c.cb = 9'(256); end
         default: begin c.cr = 9'(cl + srand(20, 60)); c.cb = 9'(ct + srand(20, 60)); end
      endcase
      c.xa = 12'(srand(-5, 40));
      c.ya = 12'(srand(-5, 40));
      if (sel < 40) begin
         c.op = OP_READ;
         c.xa = 12'(srand(-2, 60));
         c.ya = 12'(srand(-2, 60));
      end else if (sel < 60) begin
         c.op = OP_RECT;
         c.xb = 12'(int'(c.xa) + srand(-3, 20));
         c.yb = 12'(int'(c.ya) + srand(-3, 20));
      end else if (sel < 80) begin
         c.op = OP_LINE;
         c.xb = 12'(int'(c.xa) + srand(-25, 25));
         c.yb = 12'(int'(c.ya) + srand(-25, 25));
         c.bw = ($urandom_range(19) == 0) ? 5'd31 : 5'($urandom_range(7));
      end else begin
         c.op = OP_CIRCLE;
         c.xa = 12'(srand(-5, 60));
         c.ya = 12'(srand(-5, 60));
         c.rad = 8'($urandom_range(10));
      end
      return c;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 90) return srand(1, 3);
      return srand(10, 40);
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            rsp_expected.push_back(raster_predict(cur_cmd));
            op_count[cur_cmd.op]++;
            cmds_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
               cur_cmd = cmd_queue.pop_front();
               req_operation   <= cur_cmd.op;
               req_clip_left   <= cur_cmd.cl;
               req_clip_top    <= cur_cmd.ct;
               req_clip_right  <= cur_cmd.cr;
               req_clip_bottom <= cur_cmd.cb;
               req_x_a         <= cur_cmd.xa;
               req_y_a         <= cur_cmd.ya;
               req_x_b         <= cur_cmd.xb;
               req_y_b         <= cur_cmd.yb;
               req_brush_width <= cur_cmd.bw;
               req_radius      <= cur_cmd.rad;
               req_draw_color  <= cur_cmd.color;
               req_valid       <= 1'b1;
               // every third block of 20 words goes back to back
               gap_left = ((cmds_sent / 20) % 3 == 1) ? 0 : idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- response back-pressure ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         held_long = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!held_long && rsps_seen == 40) begin
         // one long hold-off while the sender keeps offering
         held_long = 1'b1;
         stall_left = 600;
         rsp_stall <= 1'b1;
      end else if ((rsps_seen / 25) % 3 == 2) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_left = idle_len();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsps_seen++;
         if (rsp_expected.size() == 0) begin
            $display("%0t: unexpected response word color=%h was_read=%b",
                     $time, rsp_read_color, rsp_was_read);
            mismatches++;
         end else begin
            w = rsp_expected.pop_front();
            if (rsp_read_color !== w.color) begin
               $display("%0t: read_color expected %h actual %h",
                        $time, w.color, rsp_read_color);
               mismatches++;
            end
            if (rsp_was_read !== w.was_read) begin
               $display("%0t: was_read expected %b actual %b",
                        $time, w.was_read, rsp_was_read);
               mismatches++;
            end
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, rsp_expected.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------- stimulus and end of run ----------------
   initial begin
      foreach (frame_px[i]) frame_px[i] = '0;

      // directed: reset contents, extremes, corner cases
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // full-frame fill with extreme rect corners
      cmd_queue.push_back(mk_cmd(OP_RECT, 0, 0, 256, 256, -2048, -2048, 2047, 2047,
                                 0, 0, 32'h80ff0000));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 255, 255, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, -1, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 2047, -2048, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 256, 0, 0, 0, 0, 0, 0));
      // inverted rect, then empty clip
      cmd_queue.push_back(mk_cmd(OP_RECT, 0, 0, 256, 256, 20, 20, 10, 30,
                                 0, 0, 32'hffffffff));
      cmd_queue.push_back(mk_cmd(OP_RECT, 50, 10, 50, 100, 0, 0, 20, 20,
                                 0, 0, 32'hffffffff));
      // zero-length line
      cmd_queue.push_back(mk_cmd(OP_LINE, 0, 0, 256, 256, 7, 7, 7, 7,
                                 5, 0, 32'hff00ff00));
      // x-major drawn from the far end, clipped with an origin offset
      cmd_queue.push_back(mk_cmd(OP_LINE, 10, 10, 200, 30, 30, 5, 2, 12,
                                 3, 0, 32'h7f0000ff));
      // y-major with negative minor slope, and a diagonal
      cmd_queue.push_back(mk_cmd(OP_LINE, 0, 0, 256, 256, 5, 40, 9, 3,
                                 0, 0, 32'hff00ffff));
      cmd_queue.push_back(mk_cmd(OP_LINE, 0, 0, 256, 256, 0, 0, 20, 20,
                                 2, 0, 32'h40ffffff));
      // long line across and beyond the frame
      cmd_queue.push_back(mk_cmd(OP_LINE, 0, 0, 256, 256, -2048, 0, 2047, 3,
                                 1, 0, 32'hffabcdef));
      // widest brush
      cmd_queue.push_back(mk_cmd(OP_LINE, 0, 0, 256, 256, 100, 100, 103, 101,
                                 31, 0, 32'h80808080));
      // circles: single point, fully off frame at max radius, opaque, transparent
      cmd_queue.push_back(mk_cmd(OP_CIRCLE, 0, 0, 256, 256, 12, 15, 0, 0,
                                 0, 0, 32'hff123456));
      cmd_queue.push_back(mk_cmd(OP_CIRCLE, 0, 0, 256, 256, -300, -300, 0, 0,
                                 0, 255, 32'hffffffff));
      cmd_queue.push_back(mk_cmd(OP_CIRCLE, 0, 0, 256, 256, 50, 50, 0, 0,
                                 0, 40, 32'hff123456));
      cmd_queue.push_back(mk_cmd(OP_CIRCLE, 0, 0, 256, 256, 60, 60, 0, 0,
                                 0, 10, 32'h00ffffff));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 50, 50, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 12, 15, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 101, 100, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 35, 16, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 60, 60, 0, 0, 0, 0, 0));

      for (int i = 0; i < 117; i++) cmd_queue.push_back(rand_cmd());
      total_cmds = cmd_queue.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (cmds_sent < total_cmds || rsp_expected.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d commands: %0d rect, %0d line, %0d circle, %0d read; %0d responses",
               cmds_sent, op_count[OP_RECT], op_count[OP_LINE],
               op_count[OP_CIRCLE], op_count[OP_READ], rsps_seen);
      if (mismatches == 0 && rsp_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/bsre_pkg.sv
rtl/core/bsre_frame_ram.sv
rtl/core/blended_shape_raster_engine.sv
dv/testbench.sv
